// File: hw/rtl/sbp_pkg.sv
// Shared types and constants for the sample buffer player.
// No dependencies.
package sbp_pkg;
    localparam int MEM_DEPTH_DEF   = 65536;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam logic [23:0] UNITY_SPEED = 24'h010000;
    localparam logic [3:0]  MAX_BLOCK_LOG2 = 4'd10;

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_START = 2'd1,
        FN_TICK  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        CFG_FRAME_TOTAL = 3'd0,
        CFG_STEREO      = 3'd1,
        CFG_LOOP        = 3'd2,
        CFG_SPEED       = 3'd3,
        CFG_BLOCK_LOG2  = 3'd4
    } t_cfg_idx;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_RD0   = 11'b00000000010,
        ST_RD1   = 11'b00000000100,
        ST_RD2   = 11'b00000001000,
        ST_RD3   = 11'b00000010000,
        ST_WAIT  = 11'b00000100000,
        ST_MUL   = 11'b00001000000,
        ST_ACC   = 11'b00010000000,
        ST_SQRT  = 11'b00100000000,
        ST_SQW   = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } t_state;

    // Square root unit control/status
    typedef struct packed {
        logic start;
    } t_sqrt_ctl;
    typedef struct packed {
        logic        busy;
        logic [20:0] root;
    } t_sqrt_sts;
endpackage

// File: hw/rtl/sbp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module sbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write or read one word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// File: hw/rtl/sbp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on sbp_pkg.
module sbp_isqrt
    import sbp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_ctl   i_ctl,
    input  logic [41:0] i_value,
    output t_sqrt_sts   o_sts
);
    logic [41:0] r_v, n_v;
    logic [41:0] r_r, n_r;
    logic [41:0] r_bit;
    logic        r_busy;
    logic [41:0] sum;

    assign sum = r_r + r_bit;

    // One digit per cycle
    always_comb begin
        if (r_v >= sum) begin
            n_v = r_v - sum;
            n_r = (r_r >> 1) + r_bit;
        end else begin
            n_v = r_v;
            n_r = r_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_v    <= i_value;
            r_r    <= '0;
            r_bit  <= 42'd1 << 40;
        end else if (r_busy) begin
            r_v   <= n_v;
            r_r   <= n_r;
            r_bit <= r_bit >> 2;
            if (r_bit[0]) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.root = r_r[20:0];
endmodule

// File: hw/rtl/sample_buffer_player_core.sv
// Sample buffer player top level: control sequencer around the sample memory.
// Depends on sbp_pkg, sbp_ram, sbp_isqrt.
//
// A load, start or ignored request is taken in idle. A tick runs the read, wait
// and output states, with multiply and accumulate unless interpolating (output
// only while stopped); one closing an RMS block waits for the bit-serial sqrt.
// Frames are fetched one word per cycle from the single-port sample memory,
// which bounds a stereo interpolating tick at four reads. The memory has no
// reset; reading a word never loaded gives undefined playback. The result
// sits in an output register, so the next request is taken while it waits.
module sample_buffer_player_core
    import sbp_pkg::*;
#(
    parameter int MEM_DEPTH   = MEM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // func[1:0], sample_addr[17:2], sample_value[33:18],
    // mix_left[49:34], mix_right[65:50], zero pad
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_left[15:0], out_right[31:16], is_playing[32], level[47:33],
    // level_valid[48], zero pad
    output logic [55:0] m_axis_tdata
);
    localparam int AW = $clog2(MEM_DEPTH);

    // Configuration
    logic [16:0] r_frame_total;
    logic        r_stereo, r_loop;
    logic [23:0] r_speed;
    logic [3:0]  r_block_log2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_total <= 17'h10000;
            r_stereo      <= 1'b0;
            r_loop        <= 1'b0;
            r_speed       <= UNITY_SPEED;
            r_block_log2  <= 4'd8;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_TOTAL: r_frame_total <= i_cfg_data[16:0];
                CFG_STEREO:      r_stereo      <= i_cfg_data[0];
                CFG_LOOP:        r_loop        <= i_cfg_data[0];
                CFG_SPEED:       r_speed       <= i_cfg_data;
                CFG_BLOCK_LOG2:  r_block_log2  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Playback state
    t_state      r_state;
    logic [31:0] r_pos;
    logic        r_active;
    logic [41:0] r_sq;
    logic [9:0]  r_bcnt;
    logic [14:0] r_level;
    logic [15:0] r_ml, r_mr;
    logic        r_interp;
    logic        r_valid_blk;
    logic signed [16:0] r_a0, r_a1;
    logic signed [17:0] r_vl, r_vr;
    logic [2:0]  r_rd;

    // Output register
    logic        r_ovalid;
    logic [55:0] r_odata;

    // Memory port
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [15:0]   ram_rdata;
    logic [SAMPLE_BITS_DEF-1:0] ram_wdata, ram_q;

    assign ram_wdata = SAMPLE_BITS_DEF'(s_axis_tdata[33:18]);
    assign ram_rdata = 16'(ram_q);

    sbp_ram #(.WIDTH(SAMPLE_BITS_DEF), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_q)
    );

    // Square root unit
    t_sqrt_ctl   r_sq_ctl;
    t_sqrt_sts   sq_sts;
    logic [3:0]  lg;
    logic [41:0] sq_shift;
    logic        blk_end;
    assign lg       = (r_block_log2 > MAX_BLOCK_LOG2) ? MAX_BLOCK_LOG2 : r_block_log2;
    assign sq_shift = r_sq >> lg;
    assign blk_end  = {1'b0, r_bcnt} >= 11'((11'd1 << lg) - 11'd1);

    sbp_isqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (r_sq_ctl),
        .i_value(sq_shift),
        .o_sts  (sq_sts)
    );

    // Kick the root unit when a block closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_ctl.start <= 1'b0;
        end else begin
            r_sq_ctl.start <= (r_state == ST_ACC) && blk_end;
        end
    end

    // Derived position values
    logic [16:0] total;
    logic [15:0] fl;
    logic [16:0] fl1;
    logic        unity_end, sp_end;
    logic [32:0] np;
    assign total     = (r_frame_total == 17'd0) ? 17'd1 : r_frame_total;
    assign fl        = r_pos[31:16];
    assign fl1       = {1'b0, fl} + 17'd1;
    assign sp_end    = fl1 >= total;
    assign unity_end = ({1'b0, r_pos} + 33'd1) >= {16'd0, total};
    assign np        = {1'b0, r_pos} + {9'd0, r_speed};

    // Word address for read number k
    logic [32:0] frame_idx;
    logic [33:0] wa;
    logic [1:0]  word_off;
    always_comb begin
        frame_idx = r_interp ? {17'd0, fl} : {1'b0, r_pos};
        // interpolating: k=0 2f, k=1 2f+2, k=2 2f+1, k=3 2f+3; else left 2f, right 2f+1
        word_off = r_interp ? {r_rd[0], r_rd[1]} : r_rd[1:0];
        if (!r_stereo) begin
            wa = {1'b0, frame_idx};
        end else begin
            wa = {frame_idx, 1'b0} + {32'd0, word_off};
        end
    end

    logic tick_in;
    t_func fn;
    assign fn = t_func'(s_axis_tdata[1:0]);
    assign s_axis_tready = (r_state == ST_IDLE);

    always_comb begin
        ram_we   = 1'b0;
        ram_addr = AW'(wa);
        if (r_state == ST_IDLE) begin
            ram_we   = s_axis_tvalid && s_axis_tready && fn == FN_LOAD;
            ram_addr = AW'(s_axis_tdata[17:2]);
        end
    end
    assign tick_in = s_axis_tvalid && s_axis_tready && fn == FN_TICK;

    // Interpolation: a + (b-a)*frac rounded
    logic signed [17:0] diff;
    logic signed [34:0] prod;
    logic signed [35:0] t;
    logic signed [18:0] ival;
    logic signed [16:0] cur;
    assign cur  = $signed({ram_rdata[15], ram_rdata});
    assign diff = 18'(cur) - 18'(r_a0);
    assign prod = diff * $signed({1'b0, r_pos[15:0]});
    assign t    = 36'($signed({r_a0, 16'd0})) + 36'(prod) + 36'sd32768;
    assign ival = t[34:16];

    // Saturating mix
    function automatic logic [15:0] sat16(input logic signed [18:0] x);
        if (x > 19'sd32767) return 16'h7fff;
        if (x < -19'sd32768) return 16'h8000;
        return x[15:0];
    endfunction

    logic signed [18:0] sl, sr;
    assign sl = 19'($signed(r_ml)) + 19'(r_vl);
    assign sr = 19'($signed(r_mr)) + 19'(r_vr);

    logic [35:0] vsq;
    assign vsq = 36'(r_vl * r_vl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_pos    <= '0;
            r_active <= 1'b0;
            r_sq     <= '0;
            r_bcnt   <= '0;
            r_level  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != ST_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        if (fn == FN_START) begin
                            r_pos <= '0; r_active <= 1'b1; r_sq <= '0;
                            r_bcnt <= '0; r_level <= '0;
                        end else if (tick_in) begin
                            r_ml <= s_axis_tdata[49:34];
                            r_mr <= s_axis_tdata[65:50];
                            r_vl <= '0; r_vr <= '0;
                            r_valid_blk <= 1'b0;
                            r_interp <= r_stereo && (r_speed != UNITY_SPEED);
                            r_rd <= '0;
                            if (!r_active) begin
                                r_sq <= '0; r_bcnt <= '0; r_level <= '0;
                                r_state <= ST_OUT;
                            end else begin
                                r_state <= ST_RD0;
                            end
                        end
                    end
                end
                ST_RD0: begin
                    // address k=0 issued
                    r_rd <= 3'd1;
                    r_state <= ST_RD1;
                end
                ST_RD1: begin
                    r_a0 <= cur;
                    r_rd <= 3'd2;
                    r_state <= r_interp ? ST_RD2 : (r_stereo ? ST_RD2 : ST_WAIT);
                    if (!r_stereo) begin
                        r_vl <= 18'(cur); r_vr <= 18'(cur);
                    end else if (!r_interp) begin
                        r_vl <= 18'(cur);
                    end
                end
                ST_RD2: begin
                    // data of k=1 arrives
                    if (r_interp) begin
                        r_a1 <= 17'(ival);
                    end else begin
                        r_vr <= 18'(cur);
                    end
                    r_rd <= 3'd3;
                    r_state <= r_interp ? ST_RD3 : ST_WAIT;
                end
                ST_RD3: begin
                    // data of k=2 (right0) arrives
                    r_a0 <= cur;
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (r_interp) begin
                        // data of k=3 (right1)
                        if (sp_end) begin
                            r_active <= 1'b0;
                            r_vl <= '0; r_vr <= '0;
                        end else begin
                            r_vl <= 18'(r_a1);
                            r_vr <= 18'(ival);
                        end
                        r_pos <= np[32] ? 32'hffffffff : np[31:0];
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_sq <= r_sq + 42'(vsq);
                    if (unity_end) begin
                        if (!r_loop) r_active <= 1'b0;
                        r_pos <= '0;
                    end else begin
                        r_pos <= r_pos + 32'd1;
                    end
                    r_state <= ST_ACC;
                end
                ST_ACC: begin
                    if (blk_end) begin
                        r_valid_blk <= 1'b1;
                        r_state <= ST_SQRT;
                    end else begin
                        r_bcnt <= r_bcnt + 10'd1;
                        r_state <= ST_OUT;
                    end
                end
                ST_SQRT: begin
                    r_state <= ST_SQW;
                end
                ST_SQW: begin
                    if (!sq_sts.busy) begin
                        r_level <= (sq_sts.root > 21'd32767) ? 15'h7fff : sq_sts.root[14:0];
                        r_sq <= '0;
                        r_bcnt <= '0;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {7'd0, r_valid_blk, r_level, r_active, sat16(sr), sat16(sl)};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
